// ===== design/ir_code_pulse_unpacker_top_assert.svh =====
// assertion macros for the ir code pulse unpacker
`ifndef IR_CODE_PULSE_UNPACKER_TOP_ASSERT_SVH
`define IR_CODE_PULSE_UNPACKER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ICPU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ICPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/icpu_pkg.sv =====
package icpu_pkg;

	localparam int TABLE_DEPTH_DEF     = 16;
	localparam int MAX_INDEX_WIDTH_DEF = 4;
	localparam int BYTE_BITS           = 8;
	localparam int BIT_CNT_W           = 4;
	localparam int ENTRY_W             = 32;

	// request kinds
	localparam logic REQ_TABLE_LOAD = 1'b0;
	localparam logic REQ_CODE_BYTE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_LOOKUP,
		ST_BAD
	} state_t;

	typedef enum logic [2:0] {
		PH_CARRIER,
		PH_COUNT,
		PH_WIDTH,
		PH_ADDR_HI,
		PH_ADDR_LO,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  code_byte;
		logic [3:0]  entry_index;
		logic [15:0] entry_on_time;
		logic [15:0] entry_off_time;
	} req_t;

	typedef struct packed {
		logic [7:0]  carrier_divider;
		logic        pulsed;
		logic [15:0] on_time;
		logic [15:0] off_time;
		logic        last_pair;
		logic        bad_width;
	} res_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} sh_ctl_t;

	typedef struct packed {
		logic done;
		logic last_bit;
		logic empty;
	} sh_stat_t;

endpackage

// ===== design/icpu_ram.sv =====
module icpu_ram #(
	parameter int WIDTH = icpu_pkg::ENTRY_W,
	parameter int DEPTH = icpu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/icpu_shifter.sv =====
module icpu_shifter #(
	parameter int TABLE_DEPTH     = icpu_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_INDEX_WIDTH = icpu_pkg::MAX_INDEX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  icpu_pkg::sh_ctl_t                    ctl,
	input  logic [icpu_pkg::BYTE_BITS-1:0]       byte_in,
	input  logic [$clog2(MAX_INDEX_WIDTH+1)-1:0] width,
	output icpu_pkg::sh_stat_t                   stat,
	output logic [$clog2(TABLE_DEPTH)-1:0]       index
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int WW = $clog2(MAX_INDEX_WIDTH + 1);

	logic [icpu_pkg::BYTE_BITS-1:0] byte_q;
	logic [icpu_pkg::BIT_CNT_W-1:0] bits_left_q;
	logic [AW-1:0]                  acc_q;
	logic [WW-1:0]                  pbits_q;

	logic [AW:0]   acc_dbl;
	logic [AW-1:0] acc_next;
	logic [WW-1:0] pbits_inc;

	// index kept reduced modulo the table depth one bit at a time
	always_comb begin
		acc_dbl = {acc_q, byte_q[icpu_pkg::BYTE_BITS-1]};
		if (acc_dbl >= (AW+1)'(TABLE_DEPTH)) begin
			acc_next = AW'(acc_dbl - (AW+1)'(TABLE_DEPTH));
		end else begin
			acc_next = AW'(acc_dbl);
		end
		pbits_inc = pbits_q + WW'(1);
	end

	assign stat.done     = ctl.step && (pbits_inc >= width);
	assign stat.last_bit = (bits_left_q == icpu_pkg::BIT_CNT_W'(1));
	assign stat.empty    = (bits_left_q == '0);
	assign index         = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= '0;
			acc_q       <= '0;
			pbits_q     <= '0;
		end else if (ctl.flush) begin
			bits_left_q <= '0;
			acc_q       <= '0;
			pbits_q     <= '0;
		end else if (ctl.load) begin
			bits_left_q <= icpu_pkg::BIT_CNT_W'(icpu_pkg::BYTE_BITS);
		end else if (ctl.step) begin
			bits_left_q <= bits_left_q - icpu_pkg::BIT_CNT_W'(1);
			if (stat.done) begin
				acc_q   <= '0;
				pbits_q <= '0;
			end else begin
				acc_q   <= acc_next;
				pbits_q <= pbits_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= byte_in;
		end else if (ctl.step) begin
			byte_q <= {byte_q[icpu_pkg::BYTE_BITS-2:0], 1'b0};
		end
	end

endmodule

// ===== design/ir_code_pulse_unpacker_top.sv =====
// ir code pulse unpacker: takes code stream bytes and timing table loads on the
// req channel and returns one on/off pair per packed table index on the res
// channel. a table load or a legal header byte is taken with no stall; a bad
// width byte holds the input while its error result is loaded. a data byte is
// unpacked msb first through a bit shifter, one bit per cycle except while a
// completed index waits on its registered timing table read, and it holds the
// input until all its bits are shifted and every index completed in it is looked
// up. on the byte that ends the code the shifter stops at the final index and the
// leftover bits are dropped. a result waits in the output register while the res
// side stalls; the shifter pauses until the register is free. a bad header width
// gives one result with bad_width set and parsing restarts at the carrier byte.
`include "ir_code_pulse_unpacker_top_assert.svh"

module ir_code_pulse_unpacker_top #(
	parameter int TABLE_DEPTH     = icpu_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_INDEX_WIDTH = icpu_pkg::MAX_INDEX_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  icpu_pkg::req_t req_data,
	output logic           res_valid,
	input  logic           res_stall,
	output icpu_pkg::res_t res_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int WW = $clog2(MAX_INDEX_WIDTH + 1);

	// control state
	icpu_pkg::state_t state_q, state_nxt;
	icpu_pkg::phase_t phase_q;

	// header fields of the current code
	logic [7:0]    carrier_q;
	logic [7:0]    pairs_q;
	logic [WW-1:0] width_q;

	// output register
	icpu_pkg::res_t res_q;
	logic           res_valid_q;

	// handshake and decode
	logic in_xfer, code_xfer, load_xfer, out_free, width_bad, last_now;
	logic [7:0] b;
	logic width_ok;

	// datapath control
	icpu_pkg::sh_ctl_t  sh_ctl;
	icpu_pkg::sh_stat_t sh_stat;
	logic [AW-1:0]      sh_index;
	logic               ram_wr_en, ram_rd_en;
	logic [31:0]        ram_rd_data;
	logic               out_load;
	icpu_pkg::res_t     out_next;

	assign req_stall = (state_q != icpu_pkg::ST_IDLE);
	assign in_xfer   = req_valid && !req_stall;
	assign code_xfer = in_xfer && (req_data.req_type == icpu_pkg::REQ_CODE_BYTE);
	assign load_xfer = in_xfer && (req_data.req_type == icpu_pkg::REQ_TABLE_LOAD);
	assign b         = req_data.code_byte;
	assign width_bad = (b == 8'd0) || (int'(b) > MAX_INDEX_WIDTH);
	assign out_free  = !res_valid_q || !res_stall;
	// this pair ends the code
	assign last_now  = (pairs_q == 8'd1);
	// stored width is legal
	assign width_ok  = (width_q != '0) && (int'(width_q) <= MAX_INDEX_WIDTH);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			icpu_pkg::ST_IDLE: begin
				if (code_xfer && phase_q == icpu_pkg::PH_WIDTH && width_bad) begin
					state_nxt = icpu_pkg::ST_BAD;
				end else if (code_xfer && phase_q == icpu_pkg::PH_DATA) begin
					state_nxt = icpu_pkg::ST_SHIFT;
				end
			end
			icpu_pkg::ST_SHIFT: begin
				if (sh_stat.done) begin
					state_nxt = icpu_pkg::ST_LOOKUP;
				end else if (sh_stat.last_bit) begin
					state_nxt = icpu_pkg::ST_IDLE;
				end
			end
			icpu_pkg::ST_LOOKUP: begin
				if (out_free) begin
					if (last_now || sh_stat.empty) begin
						state_nxt = icpu_pkg::ST_IDLE;
					end else begin
						state_nxt = icpu_pkg::ST_SHIFT;
					end
				end
			end
			icpu_pkg::ST_BAD: begin
				if (out_free) begin
					state_nxt = icpu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = icpu_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		sh_ctl    = '0;
		ram_wr_en = 1'b0;
		ram_rd_en = 1'b0;
		out_load  = 1'b0;
		out_next  = '0;
		out_next.carrier_divider = carrier_q;
		out_next.pulsed          = (carrier_q != 8'd0);
		case (state_q)
			icpu_pkg::ST_IDLE: begin
				// entries beyond the table are dropped
				ram_wr_en = load_xfer && (int'(req_data.entry_index) < TABLE_DEPTH);
				if (code_xfer) begin
					case (phase_q)
						icpu_pkg::PH_CARRIER: sh_ctl.flush = 1'b1;
						icpu_pkg::PH_WIDTH:   sh_ctl.flush = width_bad;
						icpu_pkg::PH_DATA:    sh_ctl.load  = 1'b1;
						default:              sh_ctl.flush = 1'b0;
					endcase
				end
			end
			icpu_pkg::ST_SHIFT: begin
				sh_ctl.step = 1'b1;
				// index complete: start the table read
				ram_rd_en   = sh_stat.done;
			end
			icpu_pkg::ST_LOOKUP: begin
				out_load           = out_free;
				out_next.on_time   = ram_rd_data[31:16];
				out_next.off_time  = ram_rd_data[15:0];
				out_next.last_pair = last_now;
				// leftover bits of the final byte are thrown away
				sh_ctl.flush       = out_free && last_now;
			end
			icpu_pkg::ST_BAD: begin
				out_load           = out_free;
				out_next.bad_width = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= icpu_pkg::ST_IDLE;
			phase_q     <= icpu_pkg::PH_CARRIER;
			carrier_q   <= '0;
			pairs_q     <= '0;
			width_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			// header parsing, one byte per transfer
			if (code_xfer) begin
				case (phase_q)
					icpu_pkg::PH_CARRIER: begin
						carrier_q <= b;
						phase_q   <= icpu_pkg::PH_COUNT;
					end
					icpu_pkg::PH_COUNT: begin
						pairs_q <= b;
						phase_q <= icpu_pkg::PH_WIDTH;
					end
					icpu_pkg::PH_WIDTH: begin
						if (width_bad) begin
							phase_q <= icpu_pkg::PH_CARRIER;
						end else begin
							width_q <= WW'(b);
							phase_q <= icpu_pkg::PH_ADDR_HI;
						end
					end
					icpu_pkg::PH_ADDR_HI: begin
						phase_q <= icpu_pkg::PH_ADDR_LO;
					end
					icpu_pkg::PH_ADDR_LO: begin
						// a code with no pairs ends here
						phase_q <= (pairs_q == 8'd0) ? icpu_pkg::PH_CARRIER
						                             : icpu_pkg::PH_DATA;
					end
					icpu_pkg::PH_DATA: begin
						phase_q <= icpu_pkg::PH_DATA;
					end
					default: begin
						phase_q <= icpu_pkg::PH_CARRIER;
					end
				endcase
			end

			// pair emitted
			if (state_q == icpu_pkg::ST_LOOKUP && out_load) begin
				pairs_q <= pairs_q - 8'd1;
				if (last_now) begin
					phase_q <= icpu_pkg::PH_CARRIER;
				end
			end

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= out_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	icpu_shifter #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.MAX_INDEX_WIDTH(MAX_INDEX_WIDTH)
	) u_shifter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sh_ctl),
		.byte_in(b),
		.width  (width_q),
		.stat   (sh_stat),
		.index  (sh_index)
	);

	icpu_ram #(
		.WIDTH(icpu_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(AW'(req_data.entry_index)),
		.wr_data({req_data.entry_on_time, req_data.entry_off_time}),
		.rd_en  (ram_rd_en),
		.rd_addr(sh_index),
		.rd_data(ram_rd_data)
	);

	// a result never overwrites one that is still waiting
	`ICPU_ASSERT_NOW(a_out_load_free, out_load, (!res_valid || !res_stall), "result overwritten")
	// a table read is always followed by the lookup state
	`ICPU_ASSERT_NEXT(a_read_lookup, ram_rd_en, (state_q == icpu_pkg::ST_LOOKUP), "read lost")
	// data bytes are only unpacked with a legal index width
	`ICPU_ASSERT_NOW(a_data_width, (phase_q == icpu_pkg::PH_DATA), width_ok, "illegal data width")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	// quiet cycles allowed before the run is declared hung; covers the long
	// receiver hold-off plus a data byte that yields eight pairs under stall
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int HOLDOFF_AT     = 160;
	localparam int TAIL_CYCLES    = 40;
	localparam int TARGET_ITEMS   = 310;

	// receiver stall styles
	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	// one queued request plus a flag that holds it back until all pairs are in
	typedef struct packed {
		logic           drain;
		icpu_pkg::req_t rq;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	icpu_pkg::req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	icpu_pkg::res_t res_data;

	ir_code_pulse_unpacker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// queues and counters
	// ---------------------------------------------------------------
	stim_t          code_stream_q[$];  // requests waiting for the driver
	icpu_pkg::res_t expected_pairs[$]; // predicted results, oldest first
	bit             loaded[16];        // entries written so far, seen by the generator

	int sent_count;
	int load_count;
	int pairs_checked;
	int code_ends;
	int width_errs;
	int unpulsed_pairs;
	int errors;

	// ---------------------------------------------------------------
	// predictor state
	// ---------------------------------------------------------------
	icpu_pkg::phase_t parse_ph;
	logic [7:0]  carrier_q;
	logic [7:0]  pairs_q;
	logic [2:0]  width_q;
	logic [3:0]  idx_acc;
	logic [2:0]  bits_acc;
	logic [31:0] pulse_table[16];

	task automatic clear_bits();
		idx_acc = '0;
		bits_acc = '0;
	endtask

	task automatic reset_predictor();
		parse_ph = icpu_pkg::PH_CARRIER;
		carrier_q = '0;
		pairs_q = '0;
		width_q = '0;
		clear_bits();
		for (int i = 0; i < 16; i++)
			pulse_table[i] = '0;
	endtask

	function automatic icpu_pkg::res_t make_pair(input logic [15:0] on_t,
			input logic [15:0] off_t, input logic last, input logic bad);
		icpu_pkg::res_t p;
		p.carrier_divider = carrier_q;
		p.pulsed = (carrier_q != 8'd0);
		p.on_time = on_t;
		p.off_time = off_t;
		p.last_pair = last;
		p.bad_width = bad;
		return p;
	endfunction

	// advance the parser by one accepted request and queue the pairs it yields
	task automatic predict_pairs(input icpu_pkg::req_t rq);
		logic [31:0] ent;
		bit stop;
		if (rq.req_type == icpu_pkg::REQ_TABLE_LOAD) begin
			// table loads never disturb the parse
			if (int'(rq.entry_index) < icpu_pkg::TABLE_DEPTH_DEF)
				pulse_table[rq.entry_index] = {rq.entry_on_time, rq.entry_off_time};
		end else begin
			case (parse_ph)
				icpu_pkg::PH_CARRIER: begin
					// a new code drops any leftover bits
					clear_bits();
					carrier_q = rq.code_byte;
					parse_ph = icpu_pkg::PH_COUNT;
				end
				icpu_pkg::PH_COUNT: begin
					pairs_q = rq.code_byte;
					parse_ph = icpu_pkg::PH_WIDTH;
				end
				icpu_pkg::PH_WIDTH: begin
					width_q = rq.code_byte[2:0];
					if (rq.code_byte == 8'd0 ||
							rq.code_byte > icpu_pkg::MAX_INDEX_WIDTH_DEF) begin
						// illegal width: one error pair, back to the carrier byte
						expected_pairs.push_back(make_pair(16'd0, 16'd0, 1'b0, 1'b1));
						clear_bits();
						parse_ph = icpu_pkg::PH_CARRIER;
					end else begin
						parse_ph = icpu_pkg::PH_ADDR_HI;
					end
				end
				icpu_pkg::PH_ADDR_HI: parse_ph = icpu_pkg::PH_ADDR_LO;
				icpu_pkg::PH_ADDR_LO: parse_ph = (pairs_q == 8'd0) ? icpu_pkg::PH_CARRIER
				                                                  : icpu_pkg::PH_DATA;
				icpu_pkg::PH_DATA: begin
					stop = 1'b0;
					for (int k = 7; k >= 0; k--) begin
						if (!stop) begin
							idx_acc = {idx_acc[2:0], rq.code_byte[k]};
							bits_acc = bits_acc + 3'd1;
							if (bits_acc >= width_q) begin
								ent = pulse_table[idx_acc];
								clear_bits();
								pairs_q = pairs_q - 8'd1;
								expected_pairs.push_back(make_pair(ent[31:16], ent[15:0],
									pairs_q == 8'd0, 1'b0));
								// last pair: rest of the byte is thrown away
								if (pairs_q == 8'd0) begin
									parse_ph = icpu_pkg::PH_CARRIER;
									stop = 1'b1;
								end
							end
						end
					end
				end
				default: begin
					clear_bits();
					parse_ph = icpu_pkg::PH_CARRIER;
				end
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------
	function automatic logic [15:0] pick_time();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hFFFF;
		else
			return 16'($urandom);
	endfunction

	task automatic add_load(input logic [3:0] idx, input logic [15:0] on_t,
			input logic [15:0] off_t, input bit dr);
		stim_t s;
		s.drain = dr;
		s.rq.req_type = icpu_pkg::REQ_TABLE_LOAD;
		s.rq.code_byte = 8'($urandom);
		s.rq.entry_index = idx;
		s.rq.entry_on_time = on_t;
		s.rq.entry_off_time = off_t;
		loaded[idx] = 1'b1;
		code_stream_q.push_back(s);
	endtask

	task automatic add_byte(input logic [7:0] b, input bit dr);
		stim_t s;
		s.drain = dr;
		s.rq.req_type = icpu_pkg::REQ_CODE_BYTE;
		s.rq.code_byte = b;
		s.rq.entry_index = 4'($urandom);
		s.rq.entry_on_time = 16'($urandom);
		s.rq.entry_off_time = 16'($urandom);
		code_stream_q.push_back(s);
	endtask

	// whole code: header, then if the width is legal packed indices of loaded entries
	task automatic add_code(input logic [7:0] carrier, input logic [7:0] count,
			input logic [7:0] width, input bit dr);
		bit bits_q[$];
		logic [7:0] byte_v;
		logic [3:0] ix;
		add_byte(carrier, dr);
		add_byte(count, 1'b0);
		add_byte(width, 1'b0);
		if (width >= 8'd1 && width <= icpu_pkg::MAX_INDEX_WIDTH_DEF) begin
			add_byte(8'($urandom), 1'b0);
			add_byte(8'($urandom), 1'b0);
			for (int n = 0; n < count; n++) begin
				ix = 4'($urandom_range(0, (1 << width) - 1));
				while (!loaded[ix])
					ix = 4'($urandom_range(0, (1 << width) - 1));
				for (int k = width - 1; k >= 0; k--)
					bits_q.push_back(ix[k]);
			end
			// fill the tail of the final byte with junk
			while (bits_q.size() % 8 != 0)
				bits_q.push_back(1'($urandom_range(0, 1)));
			while (bits_q.size() > 0) begin
				for (int k = 7; k >= 0; k--)
					byte_v[k] = bits_q.pop_front();
				add_byte(byte_v, 1'b0);
				// occasional table load in the middle of the data
				if (bits_q.size() > 0 && $urandom_range(0, 9) == 0)
					add_load(4'($urandom), pick_time(), pick_time(), 1'b0);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// driver: bursts of transfers with random gaps
	// ---------------------------------------------------------------
	int burst_left;
	int gap_left;
	stim_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			burst_left = 0;
			gap_left = 0;
			sent_count = 0;
			load_count = 0;
			reset_predictor();
		end else begin
			if (req_valid && !req_stall) begin
				predict_pairs(req_data);
				sent_count++;
				if (req_data.req_type == icpu_pkg::REQ_TABLE_LOAD)
					load_count++;
			end
			// a stalled request stays put, otherwise the slot is free
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (code_stream_q.size() == 0 ||
						(code_stream_q[0].drain && expected_pairs.size() != 0)) begin
					// nothing left, or waiting for every pair to drain
					req_valid <= 1'b0;
				end else begin
					next_item = code_stream_q.pop_front();
					req_valid <= 1'b1;
					req_data <= next_item.rq;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 23);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver stall pattern, with one long hold-off to back up the block
	// ---------------------------------------------------------------
	rx_mode_t rx_mode;
	int mode_left;
	int holdoff_left;
	bit holdoff_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_mode = RX_FREE;
			mode_left = 0;
			holdoff_left = 0;
			holdoff_done = 1'b0;
		end else begin
			if (!holdoff_done && sent_count >= HOLDOFF_AT) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_done = 1'b1;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 2))
						0: rx_mode = RX_FREE;
						1: rx_mode = RX_LIGHT;
						default: rx_mode = RX_HEAVY;
					endcase
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (rx_mode)
					RX_FREE: res_stall <= 1'b0;
					RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
					default: res_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: each result transfer against the oldest prediction
	// ---------------------------------------------------------------
	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
			errors++;
		end
	endtask

	icpu_pkg::res_t want_pair;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_pairs.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, res_data);
				errors++;
			end else begin
				want_pair = expected_pairs.pop_front();
				check_field("carrier_divider", 16'(want_pair.carrier_divider),
					16'(res_data.carrier_divider));
				check_field("pulsed", 16'(want_pair.pulsed), 16'(res_data.pulsed));
				check_field("on_time", want_pair.on_time, res_data.on_time);
				check_field("off_time", want_pair.off_time, res_data.off_time);
				check_field("last_pair", 16'(want_pair.last_pair),
					16'(res_data.last_pair));
				check_field("bad_width", 16'(want_pair.bad_width),
					16'(res_data.bad_width));
				pairs_checked++;
				if (want_pair.last_pair)
					code_ends++;
				if (want_pair.bad_width)
					width_errs++;
				if (!want_pair.pulsed)
					unpulsed_pairs++;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog on cycles with no transfer on either side
	// ---------------------------------------------------------------
	int quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus, reset and end of run
	// ---------------------------------------------------------------
	int drain_mark;
	int kind;
	bit drain_now;
	logic [7:0] wid;
	logic [7:0] cnt;

	initial begin
		for (int i = 0; i < 16; i++)
			loaded[i] = 1'b0;

		// directed: extreme table entries
		add_load(4'd0, 16'h0000, 16'hFFFF, 1'b0);
		add_load(4'd15, 16'hFFFF, 16'h0000, 1'b0);
		add_load(4'd1, pick_time(), pick_time(), 1'b0);
		// unpulsed code, width 4, indices 15 then 0
		add_byte(8'h00, 1'b0);
		add_byte(8'h02, 1'b0);
		add_byte(8'h04, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hF0, 1'b0);
		// width of zero and width just past the limit
		add_code(8'hFF, 8'h03, 8'h00, 1'b0);
		add_code(8'h55, 8'h01, 8'h05, 1'b0);
		// code with no pairs at all
		add_code(8'h80, 8'h00, 8'h02, 1'b0);
		// width 1, nine pairs across two bytes, table load in between
		add_byte(8'h38, 1'b0);
		add_byte(8'h09, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_load(4'd1, pick_time(), pick_time(), 1'b0);
		add_byte(8'h7F, 1'b0);

		// full pair count once, narrow so it stays short
		add_code(8'($urandom), 8'd255, 8'd1, 1'b0);

		// random codes, some broken, some noise loads
		drain_mark = 120;
		while (code_stream_q.size() < TARGET_ITEMS) begin
			// past each mark the next item waits until every pair is back
			drain_now = (code_stream_q.size() >= drain_mark);
			if (drain_now)
				drain_mark += 100;
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				add_load(4'($urandom), pick_time(), pick_time(), drain_now);
			end else begin
				if (kind < 22)
					wid = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(5, 255));
				else
					wid = 8'($urandom_range(1, icpu_pkg::MAX_INDEX_WIDTH_DEF));
				if (kind >= 22 && kind < 30)
					cnt = 8'd0;
				else if ($urandom_range(0, 9) == 0)
					cnt = 8'($urandom_range(13, 40));
				else
					cnt = 8'($urandom_range(1, 12));
				add_code(8'($urandom), cnt, wid, drain_now);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the stream to go out and every pair to come back
		while (code_stream_q.size() != 0 || req_valid || expected_pairs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d request transfers (%0d table loads), %0d pairs checked",
			sent_count, load_count, pairs_checked);
		$display("summary: %0d codes ended, %0d width errors, %0d unpulsed, %0d mismatches",
			code_ends, width_errs, unpulsed_pairs, errors);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/icpu_pkg.sv
design/icpu_ram.sv
design/icpu_shifter.sv
design/ir_code_pulse_unpacker_top.sv
tb/sv/tb_top.sv
